FILE: sv/rgb_to_hsl_converter_macros.svh
// Assertion helpers shared by the checker.
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define RGB2HSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled word keeps valid high and its payload unchanged.
`define RGB2HSL_ASSERT_HOLD(label, vld, rdy, data) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(data))) else $error("stalled word changed");

`endif

FILE: sv/rgb2hsl_pkg.sv
package rgb2hsl_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int LIGHT_BITS   = CHANNEL_BITS + 1;
    localparam int Q_BITS       = 16;
    // 6*d fits in CHANNEL_BITS+3 bits
    localparam int HDIV_BITS    = CHANNEL_BITS + 3;
    localparam int DIV_STEPS    = 2;
    localparam int DIV_STAGES   = Q_BITS / DIV_STEPS;
    localparam int PIPE_STAGES  = DIV_STAGES + 2;

    localparam logic [CHANNEL_BITS-1:0] CMAX    = '1;
    localparam logic [LIGHT_BITS-1:0]   SUM_MAX = {CMAX, 1'b0};
    localparam logic [Q_BITS-1:0]       Q_MAX   = '1;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [Q_BITS-1:0]     hue;
        logic [Q_BITS-1:0]     saturation;
        logic [LIGHT_BITS-1:0] lightness;
    } hsl_t;

    // State of both fraction divisions as it moves down the pipe
    typedef struct packed {
        logic [HDIV_BITS-1:0]    hue_div;
        logic [HDIV_BITS-1:0]    hue_rem;
        logic [Q_BITS-1:0]       hue_q;
        logic [CHANNEL_BITS-1:0] sat_den;
        logic [CHANNEL_BITS-1:0] sat_rem;
        logic [Q_BITS-1:0]       sat_q;
        logic                    sat_full;
        logic                    sat_zero;
        logic                    hue_zero;
        logic [LIGHT_BITS-1:0]   lightness;
    } div_t;

endpackage

FILE: sv/rgb2hsl_front.sv
module rgb2hsl_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rgb2hsl_pkg::pixel_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rgb2hsl_pkg::div_t     out_data
);

    localparam int CB = rgb2hsl_pkg::CHANNEL_BITS;
    localparam int LB = rgb2hsl_pkg::LIGHT_BITS;
    localparam int HB = rgb2hsl_pkg::HDIV_BITS;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
        logic [CB-1:0] mn;
        logic [CB-1:0] mx;
        sector_t       sector;
    } ext_t;

    logic              a_valid_reg;
    ext_t              a_reg;
    ext_t              a_next;
    logic              a_ready;
    logic              b_valid_reg;
    rgb2hsl_pkg::div_t b_reg;
    rgb2hsl_pkg::div_t b_next;
    logic              b_ready;

    logic [CB-1:0]         lo_rg;
    logic [CB-1:0]         hi_rg;
    logic [CB-1:0]         d;
    logic [LB-1:0]         sum;
    logic [LB-1:0]         den_wide;
    logic [CB-1:0]         den;
    logic signed [CB+1:0]  diff;
    logic [HB-1:0]         base;
    logic [HB-1:0]         six_d;
    logic signed [HB:0]    num;
    logic signed [HB:0]    num_fix;
    logic                  sat_zero;
    logic                  sat_full;
    logic                  hue_zero;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

    // Stage A: min, max and the max-channel sector with its tie order
    always_comb
    begin
        lo_rg     = (in_data.red < in_data.green) ? in_data.red : in_data.green;
        hi_rg     = (in_data.red > in_data.green) ? in_data.red : in_data.green;
        a_next.red   = in_data.red;
        a_next.green = in_data.green;
        a_next.blue  = in_data.blue;
        a_next.mn    = (lo_rg < in_data.blue) ? lo_rg : in_data.blue;
        a_next.mx    = (hi_rg > in_data.blue) ? hi_rg : in_data.blue;
        if (a_next.mx == in_data.red && a_next.mx != in_data.green)
        begin
            a_next.sector = SECT_RED;
        end
        else if (a_next.mx == in_data.green && a_next.mx != in_data.blue)
        begin
            a_next.sector = SECT_GREEN;
        end
        else
        begin
            a_next.sector = SECT_BLUE;
        end
    end

    // Stage B: delta, sum, saturation denominator and hue numerator
    always_comb
    begin
        d   = a_reg.mx - a_reg.mn;
        sum = {1'b0, a_reg.mn} + {1'b0, a_reg.mx};
        den_wide = rgb2hsl_pkg::SUM_MAX - sum;
        if (sum < {1'b0, rgb2hsl_pkg::CMAX})
        begin
            den = sum[CB-1:0];
        end
        else
        begin
            den = den_wide[CB-1:0];
        end
        sat_zero = (den == '0);
        sat_full = !sat_zero && (d == den);
        hue_zero = (d == '0);

        case (a_reg.sector)
            SECT_RED:
            begin
                diff = $signed({2'b00, a_reg.green}) - $signed({2'b00, a_reg.blue});
                base = '0;
            end
            SECT_GREEN:
            begin
                diff = $signed({2'b00, a_reg.blue}) - $signed({2'b00, a_reg.red});
                base = {2'b00, d, 1'b0};
            end
            SECT_BLUE:
            begin
                diff = $signed({2'b00, a_reg.red}) - $signed({2'b00, a_reg.green});
                base = {1'b0, d, 2'b00};
            end
            default:
            begin
                diff = '0;
                base = '0;
            end
        endcase

        six_d = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
        num   = $signed({1'b0, base}) + diff;
        // negative hue wraps by one full turn
        if (num < 0)
        begin
            num_fix = num + $signed({1'b0, six_d});
        end
        else
        begin
            num_fix = num;
        end

        b_next.hue_div   = six_d;
        b_next.hue_rem   = hue_zero ? '0 : num_fix[HB-1:0];
        b_next.hue_q     = '0;
        b_next.sat_den   = den;
        b_next.sat_rem   = (sat_zero || sat_full) ? '0 : d;
        b_next.sat_q     = '0;
        b_next.sat_full  = sat_full;
        b_next.sat_zero  = sat_zero;
        b_next.hue_zero  = hue_zero;
        b_next.lightness = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_reg <= a_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

endmodule

FILE: sv/rgb2hsl_div_stage.sv
module rgb2hsl_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rgb2hsl_pkg::div_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rgb2hsl_pkg::div_t out_data
);

    localparam int CB = rgb2hsl_pkg::CHANNEL_BITS;
    localparam int HB = rgb2hsl_pkg::HDIV_BITS;
    localparam int QB = rgb2hsl_pkg::Q_BITS;

    logic              valid_reg;
    rgb2hsl_pkg::div_t data_reg;
    rgb2hsl_pkg::div_t data_next;
    logic [HB:0]       hrem2;
    logic [HB:0]       hsub;
    logic [CB:0]       srem2;
    logic [CB:0]       ssub;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Restoring division, a few quotient bits per stage; remainder stays below divisor
    always_comb
    begin
        data_next = in_data;
        hrem2 = '0;
        hsub  = '0;
        srem2 = '0;
        ssub  = '0;
        for (int i = 0; i < rgb2hsl_pkg::DIV_STEPS; i++)
        begin
            hrem2 = {data_next.hue_rem, 1'b0};
            hsub  = hrem2 - {1'b0, data_next.hue_div};
            if (hrem2 >= {1'b0, data_next.hue_div})
            begin
                data_next.hue_rem = hsub[HB-1:0];
                data_next.hue_q   = {data_next.hue_q[QB-2:0], 1'b1};
            end
            else
            begin
                data_next.hue_rem = hrem2[HB-1:0];
                data_next.hue_q   = {data_next.hue_q[QB-2:0], 1'b0};
            end

            srem2 = {data_next.sat_rem, 1'b0};
            ssub  = srem2 - {1'b0, data_next.sat_den};
            if (srem2 >= {1'b0, data_next.sat_den})
            begin
                data_next.sat_rem = ssub[CB-1:0];
                data_next.sat_q   = {data_next.sat_q[QB-2:0], 1'b1};
            end
            else
            begin
                data_next.sat_rem = srem2[CB-1:0];
                data_next.sat_q   = {data_next.sat_q[QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: sv/rgb_to_hsl_converter.sv
// Two front stages, then eight stages of the 16-bit restoring fraction
// dividers, two bits each, carry a pixel to the hsl handoff.
// Throughput: one pixel per clock unless hsl_ready stalls the output; every
// stage has its own valid bit and register, so a stalled output holds while
// earlier stages keep filling.
// Reset clears only the stage valid bits; data registers are not reset.
module rgb_to_hsl_converter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  rgb2hsl_pkg::pixel_t pixel,
    output logic                hsl_valid,
    input  logic                hsl_ready,
    output rgb2hsl_pkg::hsl_t   hsl
);

    localparam int NS = rgb2hsl_pkg::DIV_STAGES;

    rgb2hsl_pkg::div_t stage_data [NS+1];
    logic [NS:0]       stage_valid;
    logic [NS:0]       stage_ready;
    rgb2hsl_pkg::div_t last;

    rgb2hsl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_ready  (pixel_ready),
        .in_data   (pixel),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar k = 0; k < NS; k++)
    begin : g_div
        rgb2hsl_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    assign stage_ready[NS] = hsl_ready;
    assign hsl_valid       = stage_valid[NS];
    assign last            = stage_data[NS];

    // grey gives zero hue; black/white zero saturation; delta equal to denominator saturates
    always_comb
    begin
        hsl.lightness = last.lightness;
        hsl.hue       = last.hue_zero ? '0 : last.hue_q;
        if (last.sat_zero)
        begin
            hsl.saturation = '0;
        end
        else if (last.sat_full)
        begin
            hsl.saturation = rgb2hsl_pkg::Q_MAX;
        end
        else
        begin
            hsl.saturation = last.sat_q;
        end
    end

endmodule

FILE: sv/rgb2hsl_checker.sv
`include "rgb_to_hsl_converter_macros.svh"

module rgb2hsl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                pixel_valid,
    input logic                pixel_ready,
    input rgb2hsl_pkg::pixel_t pixel,
    input logic                hsl_valid,
    input logic                hsl_ready,
    input rgb2hsl_pkg::hsl_t   hsl
);

    localparam int CNT_W = $clog2(rgb2hsl_pkg::PIPE_STAGES + 1);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = pixel_valid && pixel_ready;
    assign out_acc = hsl_valid && hsl_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `RGB2HSL_ASSERT_HOLD(a_out_hold, hsl_valid, hsl_ready, hsl)
    `RGB2HSL_ASSERT(a_no_phantom, hsl_valid |-> (inflight_reg != '0), "result word with no pixel in flight")
    `RGB2HSL_ASSERT(a_capacity, inflight_reg <= CNT_W'(rgb2hsl_pkg::PIPE_STAGES), "more words in flight than stages")
    `RGB2HSL_ASSERT(a_grey_hue, (hsl_valid && hsl.saturation == '0) |-> (hsl.hue == '0), "zero saturation with nonzero hue")

endmodule

bind rgb_to_hsl_converter rgb2hsl_checker u_checker (.*);

FILE: dv/rgb_to_hsl_converter_test.sv
module rgb_to_hsl_converter_test;

    localparam int CB           = rgb2hsl_pkg::CHANNEL_BITS;
    localparam int CODE_MAX     = (1 << CB) - 1;
    localparam int RANDOM_ITEMS = 750;
    localparam int CALM_ITEMS   = 150;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        rgb2hsl_pkg::pixel_t px;
        bit                  typed;
        rgb2hsl_pkg::hsl_t   want;
    } pixel_row_t;

    // Rows with typed = 1 carry hand-worked results; the others go through predict_hsl.
    localparam int NUM_ROWS = 23;
    pixel_row_t directed_rows [NUM_ROWS] = '{
        '{'{8'd0,   8'd0,   8'd0},   1'b1, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{16'd0,     16'd0,     9'd510}},
        '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{16'd0,     16'd0,     9'd256}},
        '{'{8'd255, 8'd0,   8'd0},   1'b1, '{16'd0,     16'd65535, 9'd255}},
        '{'{8'd0,   8'd255, 8'd0},   1'b1, '{16'd21845, 16'd65535, 9'd255}},
        '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{16'd43690, 16'd65535, 9'd255}},
        '{'{8'd255, 8'd255, 8'd0},   1'b1, '{16'd10922, 16'd65535, 9'd255}},
        '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{16'd32768, 16'd65535, 9'd255}},
        '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{16'd54613, 16'd65535, 9'd255}},
        '{'{8'd1,   8'd0,   8'd0},   1'b1, '{16'd0,     16'd65535, 9'd1}},
        '{'{8'd255, 8'd255, 8'd254}, 1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd255, 8'd0,   8'd10},  1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd255, 8'd0,   8'd1},   1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd255, 8'd10,  8'd0},   1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd100, 8'd50,  8'd20},  1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd200, 8'd220, 8'd250}, 1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd200, 8'd55,  8'd100}, 1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd200, 8'd54,  8'd100}, 1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd200, 8'd56,  8'd100}, 1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd10,  8'd20,  8'd20},  1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd1,   8'd1,   8'd0},   1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd0,   8'd0,   8'd1},   1'b0, '{16'd0,     16'd0,     9'd0}},
        '{'{8'd254, 8'd1,   8'd128}, 1'b0, '{16'd0,     16'd0,     9'd0}}
    };

    logic                clk;
    logic                rst_n;
    logic                pixel_valid;
    logic                pixel_ready;
    rgb2hsl_pkg::pixel_t pixel;
    logic                hsl_valid;
    logic                hsl_ready;
    rgb2hsl_pkg::hsl_t   hsl;

    // travel with the pixel word so the monitor sees a consistent pair
    logic                stim_typed;
    rgb2hsl_pkg::hsl_t   stim_want;

    rgb2hsl_pkg::hsl_t   hsl_expected [$];
    int     mismatches;
    int     pixels_in;
    int     results_out;
    int     cycles;
    bit     calm;
    bit     squeeze_req;
    bit     squeeze_done;

    rgb_to_hsl_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .hsl_valid   (hsl_valid),
        .hsl_ready   (hsl_ready),
        .hsl         (hsl)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic rgb2hsl_pkg::hsl_t predict_hsl(rgb2hsl_pkg::pixel_t px);
        int                r;
        int                g;
        int                b;
        int                lo;
        int                hi;
        int                d;
        int                sum;
        int                den;
        int                num;
        longint            q;
        rgb2hsl_pkg::hsl_t res;
        r   = int'(px.red);
        g   = int'(px.green);
        b   = int'(px.blue);
        lo  = (r < g) ? r : g;
        lo  = (lo < b) ? lo : b;
        hi  = (r > g) ? r : g;
        hi  = (hi > b) ? hi : b;
        d   = hi - lo;
        sum = hi + lo;
        res = '0;
        res.lightness = sum[rgb2hsl_pkg::LIGHT_BITS-1:0];
        if (sum > 0 && sum < 2 * CODE_MAX)
        begin
            den = (sum < CODE_MAX) ? sum : 2 * CODE_MAX - sum;
            q   = (longint'(d) << rgb2hsl_pkg::Q_BITS) / den;
            if (q > longint'(rgb2hsl_pkg::Q_MAX))
                q = longint'(rgb2hsl_pkg::Q_MAX);
            res.saturation = q[rgb2hsl_pkg::Q_BITS-1:0];
        end
        if (d > 0)
        begin
            // sector order: red, then green, then blue on ties
            if (hi == r && hi != g)
                num = g - b;
            else if (hi == g && hi != b)
                num = 2 * d + b - r;
            else
                num = 4 * d + r - g;
            if (num < 0)
                num += 6 * d;
            q = (longint'(num) << rgb2hsl_pkg::Q_BITS) / (6 * d);
            res.hue = q[rgb2hsl_pkg::Q_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic [CB-1:0] extreme_code();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return rgb2hsl_pkg::CMAX;
            2: return CB'($urandom_range(0, 2));
            default: return CB'($urandom_range(0, CODE_MAX));
        endcase
    endfunction

    function automatic rgb2hsl_pkg::pixel_t random_pixel();
        rgb2hsl_pkg::pixel_t p;
        logic [CB-1:0]       base;
        p.red   = CB'($urandom_range(0, CODE_MAX));
        p.green = CB'($urandom_range(0, CODE_MAX));
        p.blue  = CB'($urandom_range(0, CODE_MAX));
        base    = CB'($urandom_range(0, CODE_MAX));
        case ($urandom_range(0, 9))
            0:
            begin
                p.red   = base;
                p.green = base;
                p.blue  = base;
            end
            1:
            begin
                case ($urandom_range(0, 2))
                    0: p.green = p.red;
                    1: p.blue  = p.green;
                    default: p.red = p.blue;
                endcase
            end
            2:
            begin
                p.red   = extreme_code();
                p.green = extreme_code();
                p.blue  = extreme_code();
            end
            3:
            begin
                // nearly grey: tiny delta, large saturation swings
                p.red   = base;
                p.green = base ^ CB'($urandom_range(0, 3));
                p.blue  = base ^ CB'($urandom_range(0, 3));
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0d] %s mismatch: got %0d, expected %0d", cycles, field, got, want);
        mismatches++;
    endtask

    // Offer one word and hold it until taken; returns in the step of acceptance.
    task automatic send_pixel(input rgb2hsl_pkg::pixel_t px, input bit typed,
                              input rgb2hsl_pkg::hsl_t want);
        pixel       <= px;
        stim_typed  <= typed;
        stim_want   <= want;
        pixel_valid <= 1'b1;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, hsl_expected.size());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rgb2hsl_pkg::hsl_t want;
        if (rst_n)
        begin
            if (hsl_valid && hsl_ready)
            begin
                results_out++;
                if (hsl_expected.size() == 0)
                begin
                    report_mismatch("unexpected word, hue", int'(hsl.hue), -1);
                end
                else
                begin
                    want = hsl_expected.pop_front();
                    if (hsl.hue !== want.hue)
                        report_mismatch("hue", int'(hsl.hue), int'(want.hue));
                    if (hsl.saturation !== want.saturation)
                        report_mismatch("saturation", int'(hsl.saturation),
                                        int'(want.saturation));
                    if (hsl.lightness !== want.lightness)
                        report_mismatch("lightness", int'(hsl.lightness),
                                        int'(want.lightness));
                end
            end
            if (pixel_valid && pixel_ready)
            begin
                pixels_in++;
                hsl_expected.push_back(stim_typed ? stim_want : predict_hsl(pixel));
            end
        end
    end

    // Output side: random back-pressure, plus one long hold to fill the pipe.
    initial
    begin
        hsl_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                hsl_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                hsl_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            hsl_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        pixel_valid  <= 1'b0;
        pixel        <= '0;
        stim_typed   <= 1'b0;
        stim_want    <= '0;
        mismatches   = 0;
        pixels_in    = 0;
        results_out  = 0;
        cycles       = 0;
        calm         = 1'b0;
        squeeze_req  = 1'b0;
        squeeze_done = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
            sender_gap();
        end

        squeeze_req = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            send_pixel(random_pixel(), 1'b0, '0);
            sender_gap();
        end
        pixel_valid <= 1'b0;

        while (hsl_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels (%0d directed: grey, black, white, primaries, ties, hue wrap),",
                 pixels_in, NUM_ROWS);
        $display("checked %0d HSL words under random stalls and one %0d-cycle output hold",
                 results_out, HOLD_CYCLES);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
